>>> design/adsud_pkg.sv
// Package for the advertising-data service UUID detector.
// Shared types, structure-type codes, register indexes and reset values.
// No dependencies.
`default_nettype none

package adsud_pkg;

    // Advertising-data structure type codes
    localparam logic [7:0] TYPE_SERVICE_DATA = 8'h16;
    localparam logic [7:0] TYPE_LIST_PARTIAL = 8'h02;
    localparam logic [7:0] TYPE_LIST_FULL    = 8'h03;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_UUID_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_UUID_B = 1'b1;

    // Register reset values
    localparam logic [15:0] UUID_A_RESET = 16'hFE2C;
    localparam logic [15:0] UUID_B_RESET = 16'hFEF3;

    // Per-byte outcome from the parser to the result stage
    typedef struct packed {
        logic done;   // buffer ends with this byte
        logic found;  // matching UUID in a completed structure
    } parse_res_t;

endpackage : adsud_pkg

`default_nettype wire

>>> design/ad_service_uuid_detector_core.sv
// Advertising-data service UUID detector, top level.
// The result is registered in the output register when the last byte is taken.
// Throughput: one byte per cycle; a byte is held off only while a result sits in
// the output register and m_tready is low.
// Reset (rst_n, asynchronous): parser idle, UUIDs 0xFE2C / 0xFEF3, no result pending.
// Depends on adsud_pkg and adsud_parser.
`default_nettype none

module ad_service_uuid_detector_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // byte stream
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    input  wire logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  wire logic                              s_tlast,   // last_byte
    // result stream
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    output      logic [7:0]                        m_tdata,   // [0] service_found, [7:1] zero
    // configuration writes
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [adsud_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [15:0]                       cfg_data
);
    import adsud_pkg::*;

    logic [15:0] uuid_a_q_reg;
    logic [15:0] uuid_b_q_reg;
    logic        out_valid_reg;
    logic        out_found_reg;
    logic        byte_take;
    parse_res_t  res;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign byte_take = s_tvalid && s_tready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uuid_a_q_reg <= UUID_A_RESET;
            uuid_b_q_reg <= UUID_B_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_UUID_A: uuid_a_q_reg <= cfg_data;
                CFG_UUID_B: uuid_b_q_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    adsud_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_take (byte_take),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .uuid_a    (uuid_a_q_reg),
        .uuid_b    (uuid_b_q_reg),
        .res       (res)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
        end
        else
        begin
            if (byte_take && res.done)
            begin
                out_valid_reg <= 1'b1;
                out_found_reg <= res.found;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_found_reg};

endmodule : ad_service_uuid_detector_core

`default_nettype wire

>>> design/adsud_parser.sv
// Length/type/payload walker for one advertising-data buffer.
// Holds the parse state and reports the found flag on the last byte.
// Depends on adsud_pkg.
`default_nettype none

module adsud_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_take,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last_byte,
    input  wire logic [15:0]        uuid_a,
    input  wire logic [15:0]        uuid_b,
    output adsud_pkg::parse_res_t   res
);
    import adsud_pkg::*;

    typedef enum logic [1:0] {
        PH_LENGTH,
        PH_TYPE,
        PH_PAYLOAD,
        PH_STOPPED
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [7:0]  field_type_reg, field_type_next;
    logic [7:0]  offset_reg, offset_next;
    logic [7:0]  low_byte_reg, low_byte_next;
    logic        pending_reg, pending_next;
    logic        found_reg, found_next;

    logic [7:0]  left_dec;
    logic [15:0] word;
    logic        checked;

    assign left_dec = bytes_left_reg - 8'd1;
    assign word     = {data_byte, low_byte_reg};

    // UUID word is compared in lists, and in service data only as the first word
    always_comb
    begin
        checked = 1'b0;
        if (field_type_reg == TYPE_SERVICE_DATA && offset_reg == 8'd1)
            checked = 1'b1;
        if (field_type_reg == TYPE_LIST_PARTIAL || field_type_reg == TYPE_LIST_FULL)
            checked = 1'b1;
    end

    // Next parse state for the incoming byte
    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        field_type_next = field_type_reg;
        offset_next     = offset_reg;
        low_byte_next   = low_byte_reg;
        pending_next    = pending_reg;
        found_next      = found_reg;
        unique case (phase_reg)
            PH_LENGTH:
            begin
                if (data_byte == 8'd0)
                    phase_next = PH_STOPPED;
                else
                begin
                    bytes_left_next = data_byte;
                    phase_next      = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                field_type_next = data_byte;
                offset_next     = 8'd0;
                pending_next    = 1'b0;
                bytes_left_next = left_dec;
                if (left_dec == 8'd0)
                    phase_next = PH_LENGTH;
                else
                    phase_next = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                if (!offset_reg[0])
                    low_byte_next = data_byte;
                else if (checked && (word == uuid_a || word == uuid_b))
                    pending_next = 1'b1;
                offset_next     = offset_reg + 8'd1;
                bytes_left_next = left_dec;
                // structure complete: commit its match
                if (left_dec == 8'd0)
                begin
                    found_next   = found_reg | pending_next;
                    pending_next = 1'b0;
                    phase_next   = PH_LENGTH;
                end
            end
            PH_STOPPED:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign res.done  = last_byte;
    assign res.found = found_next;

    // State update; last byte returns the parser to its reset state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LENGTH;
            bytes_left_reg <= 8'd0;
            field_type_reg <= 8'd0;
            offset_reg     <= 8'd0;
            low_byte_reg   <= 8'd0;
            pending_reg    <= 1'b0;
            found_reg      <= 1'b0;
        end
        else if (byte_take)
        begin
            if (last_byte)
            begin
                phase_reg      <= PH_LENGTH;
                bytes_left_reg <= 8'd0;
                field_type_reg <= 8'd0;
                offset_reg     <= 8'd0;
                low_byte_reg   <= 8'd0;
                pending_reg    <= 1'b0;
                found_reg      <= 1'b0;
            end
            else
            begin
                phase_reg      <= phase_next;
                bytes_left_reg <= bytes_left_next;
                field_type_reg <= field_type_next;
                offset_reg     <= offset_next;
                low_byte_reg   <= low_byte_next;
                pending_reg    <= pending_next;
                found_reg      <= found_next;
            end
        end
    end

endmodule : adsud_parser

`default_nettype wire
